FILE: sv/atp_pkg.sv
`timescale 1ns / 1ps
// Shared adaptive timeout predictor package: payload, unit status and window command
// types, action, mode and register index codes, and fixed widths. Depends on nothing.
package atp_pkg;

    localparam int WINDOW_DEPTH_DEF = 50;
    localparam int DATA_W           = 32;
    localparam int CPLX_W           = 11;
    localparam int HIST_W           = 7;
    localparam int CFG_IDX_W        = 3;

    localparam int MUL_X_W     = 32;
    localparam int MUL_M_W     = 16;
    localparam int MUL_P_W     = MUL_X_W + MUL_M_W;
    localparam int Q_SHIFT     = 11;
    localparam int SCALED_W    = MUL_P_W - Q_SHIFT;
    localparam int MIX_W       = DATA_W + 3;
    localparam int MIX_DIVISOR = 5;
    localparam int ONE_Q10     = 1024;

    localparam logic [HIST_W-1:0] HISTORY_SAT = 7'd101;
    localparam logic [HIST_W-1:0] CONF_HI_TH  = 7'd100;
    localparam logic [HIST_W-1:0] CONF_MED_TH = 7'd20;

    localparam logic [1:0] CONF_LOW  = 2'd0;
    localparam logic [1:0] CONF_MED  = 2'd1;
    localparam logic [1:0] CONF_HIGH = 2'd2;

    localparam logic [1:0] ACT_RECORD  = 2'd0;
    localparam logic [1:0] ACT_PREDICT = 2'd1;
    localparam logic [1:0] ACT_CLEAR   = 2'd2;

    localparam logic [1:0] MODE_FIXED    = 2'd0;
    localparam logic [1:0] MODE_ADAPTIVE = 2'd1;
    localparam logic [1:0] MODE_COMPLEX  = 2'd2;
    localparam logic [1:0] MODE_HYBRID   = 2'd3;

    localparam logic [CFG_IDX_W-1:0] CFG_MODE  = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_BASE  = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_MIN   = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_MAX   = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_AGGR  = 3'd4;
    localparam logic [CFG_IDX_W-1:0] CFG_LEARN = 3'd5;

    localparam logic [1:0]        RST_MODE  = MODE_HYBRID;
    localparam logic [DATA_W-1:0] RST_BASE  = 32'd30000;
    localparam logic [DATA_W-1:0] RST_MIN   = 32'd5000;
    localparam logic [DATA_W-1:0] RST_MAX   = 32'd3600000;
    localparam logic [CPLX_W-1:0] RST_AGGR  = 11'd512;

    typedef struct packed {
        logic [1:0]        action;
        logic [DATA_W-1:0] duration_ms;
        logic              timed_out;
        logic [CPLX_W-1:0] complexity;
    } t_in_item;

    typedef struct packed {
        logic [DATA_W-1:0] predicted_ms;
        logic [1:0]        confidence;
    } t_out_item;

    typedef struct packed {
        logic busy;
        logic done;
    } t_unit_stat;

    typedef struct packed {
        logic              rec;
        logic              clr;
        logic [DATA_W-1:0] dur;
        logic              failed;
    } t_win_cmd;

endpackage

FILE: sv/atp_div.sv
`timescale 1ns / 1ps
// Bit-serial restoring divider: one quotient bit per cycle, MSB first.
// Depends on atp_pkg for the unit status type.
module atp_div #(
    parameter int DVD_W = 38,
    parameter int DSR_W = 6
) (
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  logic                   i_start,
    input  logic [DVD_W-1:0]       i_dividend,
    input  logic [DSR_W-1:0]       i_divisor,
    output atp_pkg::t_unit_stat    o_stat,
    output logic [DVD_W-1:0]       o_quotient
);

    localparam int CNT_W = $clog2(DVD_W + 1);

    logic             r_busy, n_busy;
    logic             r_done, n_done;
    logic [CNT_W-1:0] r_cnt, n_cnt;
    logic [DVD_W-1:0] r_q, n_q;
    logic [DSR_W-1:0] r_rem, n_rem;
    logic [DSR_W-1:0] r_dsr, n_dsr;
    logic [DSR_W:0]   trial;
    logic [DSR_W:0]   diff;
    logic             ge;

    assign trial = {r_rem, r_q[DVD_W-1]};
    assign diff  = trial - {1'b0, r_dsr};
    assign ge    = (trial >= {1'b0, r_dsr});

    always_comb begin
        n_busy = r_busy;
        n_done = 1'b0;
        n_cnt  = r_cnt;
        n_q    = r_q;
        n_rem  = r_rem;
        n_dsr  = r_dsr;
        if (i_start) begin
            n_busy = 1'b1;
            n_cnt  = CNT_W'(DVD_W);
            n_q    = i_dividend;
            n_rem  = '0;
            n_dsr  = i_divisor;
        end else if (r_busy) begin
            n_q   = {r_q[DVD_W-2:0], ge};
            n_rem = ge ? diff[DSR_W-1:0] : trial[DSR_W-1:0];
            n_cnt = r_cnt - 1'b1;
            if (r_cnt == CNT_W'(1)) begin
                n_busy = 1'b0;
                n_done = 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_busy <= n_busy;
            r_done <= n_done;
            r_cnt  <= n_cnt;
        end
    end

    always_ff @(posedge i_clk) begin
        r_q   <= n_q;
        r_rem <= n_rem;
        r_dsr <= n_dsr;
    end

    assign o_stat.busy = r_busy;
    assign o_stat.done = r_done;
    assign o_quotient  = r_q;

endmodule

FILE: sv/atp_mul.sv
`timescale 1ns / 1ps
// Serial-parallel multiplier: the serial operand enters one bit per cycle, LSB first,
// and one product bit leaves per cycle. Depends on atp_pkg for the unit status type.
module atp_mul #(
    parameter int X_W = 32,
    parameter int M_W = 16
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_start,
    input  logic [X_W-1:0]        i_x,
    input  logic [M_W-1:0]        i_m,
    output atp_pkg::t_unit_stat   o_stat,
    output logic [X_W+M_W-1:0]    o_product
);

    localparam int P_W   = X_W + M_W;
    localparam int CNT_W = $clog2(P_W + 1);

    logic             r_busy, n_busy;
    logic             r_done, n_done;
    logic [CNT_W-1:0] r_cnt, n_cnt;
    logic [X_W-1:0]   r_x, n_x;
    logic [M_W-1:0]   r_m, n_m;
    logic [M_W-1:0]   r_acc, n_acc;
    logic [P_W-1:0]   r_p, n_p;
    logic [M_W:0]     step_sum;

    assign step_sum = {1'b0, r_acc} + (r_x[0] ? {1'b0, r_m} : '0);

    always_comb begin
        n_busy = r_busy;
        n_done = 1'b0;
        n_cnt  = r_cnt;
        n_x    = r_x;
        n_m    = r_m;
        n_acc  = r_acc;
        n_p    = r_p;
        if (i_start) begin
            n_busy = 1'b1;
            n_cnt  = CNT_W'(P_W);
            n_x    = i_x;
            n_m    = i_m;
            n_acc  = '0;
            n_p    = '0;
        end else if (r_busy) begin
            n_p   = {step_sum[0], r_p[P_W-1:1]};
            n_acc = step_sum[M_W:1];
            n_x   = {1'b0, r_x[X_W-1:1]};
            n_cnt = r_cnt - 1'b1;
            if (r_cnt == CNT_W'(1)) begin
                n_busy = 1'b0;
                n_done = 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_busy <= n_busy;
            r_done <= n_done;
            r_cnt  <= n_cnt;
        end
    end

    always_ff @(posedge i_clk) begin
        r_x   <= n_x;
        r_m   <= n_m;
        r_acc <= n_acc;
        r_p   <= n_p;
    end

    assign o_stat.busy = r_busy;
    assign o_stat.done = r_done;
    assign o_product   = r_p;

endmodule

FILE: sv/atp_win.sv
`timescale 1ns / 1ps
// Sliding window of recent executions with running success sum, success count
// and saturating history count. Depends on atp_pkg for the command type and widths.
module atp_win #(
    parameter int DEPTH = atp_pkg::WINDOW_DEPTH_DEF
) (
    input  logic                                        i_clk,
    input  logic                                        i_rst_n,
    input  atp_pkg::t_win_cmd                           i_cmd,
    output logic                                        o_busy,
    output logic [atp_pkg::DATA_W+$clog2(DEPTH+1)-1:0]  o_sum,
    output logic [$clog2(DEPTH+1)-1:0]                  o_count,
    output logic [atp_pkg::HIST_W-1:0]                  o_history
);

    localparam int CNT_W  = $clog2(DEPTH + 1);
    localparam int SLOT_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int SUM_W  = atp_pkg::DATA_W + CNT_W;
    localparam int ENT_W  = atp_pkg::DATA_W + 1;

    localparam logic [1:0] W_IDLE  = 2'd0;
    localparam logic [1:0] W_EVICT = 2'd1;
    localparam logic [1:0] W_ADD   = 2'd2;

    logic [1:0]                  r_state, n_state;
    logic [CNT_W-1:0]            r_fill, n_fill;
    logic [SLOT_W-1:0]           r_slot, n_slot;
    logic [SUM_W-1:0]            r_sum, n_sum;
    logic [CNT_W-1:0]            r_count, n_count;
    logic [atp_pkg::HIST_W-1:0]  r_hist, n_hist;
    logic [atp_pkg::DATA_W-1:0]  r_dur, n_dur;
    logic                        r_fail, n_fail;
    logic [ENT_W-1:0]            r_mem [DEPTH];
    logic [ENT_W-1:0]            r_rd;
    logic                        wr_en;

    assign wr_en = (r_state == W_ADD);

    always_comb begin
        n_state = r_state;
        n_fill  = r_fill;
        n_slot  = r_slot;
        n_sum   = r_sum;
        n_count = r_count;
        n_hist  = r_hist;
        n_dur   = r_dur;
        n_fail  = r_fail;
        case (r_state)
            W_IDLE: begin
                if (i_cmd.clr) begin
                    n_fill  = '0;
                    n_slot  = '0;
                    n_sum   = '0;
                    n_count = '0;
                    n_hist  = '0;
                end else if (i_cmd.rec) begin
                    n_dur   = i_cmd.dur;
                    n_fail  = i_cmd.failed;
                    n_state = W_EVICT;
                end
            end
            W_EVICT: begin
                if (r_fill == CNT_W'(DEPTH)) begin
                    if (!r_rd[ENT_W-1]) begin
                        n_sum = r_sum - {{CNT_W{1'b0}}, r_rd[atp_pkg::DATA_W-1:0]};
                        if (r_count != '0) begin
                            n_count = r_count - 1'b1;
                        end
                    end
                end else begin
                    n_fill = r_fill + 1'b1;
                end
                n_state = W_ADD;
            end
            W_ADD: begin
                if (!r_fail) begin
                    n_sum   = r_sum + {{CNT_W{1'b0}}, r_dur};
                    n_count = r_count + 1'b1;
                end
                n_slot = (r_slot == SLOT_W'(DEPTH - 1)) ? '0 : r_slot + 1'b1;
                if (r_hist < atp_pkg::HISTORY_SAT) begin
                    n_hist = r_hist + 1'b1;
                end
                n_state = W_IDLE;
            end
            default: begin
                n_state = W_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= W_IDLE;
            r_fill  <= '0;
            r_slot  <= '0;
            r_sum   <= '0;
            r_count <= '0;
            r_hist  <= '0;
        end else begin
            r_state <= n_state;
            r_fill  <= n_fill;
            r_slot  <= n_slot;
            r_sum   <= n_sum;
            r_count <= n_count;
            r_hist  <= n_hist;
        end
    end

    always_ff @(posedge i_clk) begin
        r_dur  <= n_dur;
        r_fail <= n_fail;
    end

    always_ff @(posedge i_clk) begin
        if (wr_en) begin
            r_mem[r_slot] <= {r_fail, r_dur};
        end
        r_rd <= r_mem[r_slot];
    end

    assign o_busy    = (r_state != W_IDLE);
    assign o_sum     = r_sum;
    assign o_count   = r_count;
    assign o_history = r_hist;

    a_count_in_fill: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= r_fill)
        else $error("success count exceeds window fill");

    a_fill_in_depth: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_fill <= CNT_W'(DEPTH))
        else $error("window fill exceeds depth");

    a_hist_sat: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_hist <= atp_pkg::HISTORY_SAT)
        else $error("history count above saturation");

endmodule

FILE: sv/adaptive_timeout_predictor.sv
`timescale 1ns / 1ps
// Adaptive timeout predictor top level: configuration registers, predict sequencer,
// output register. Depends on atp_pkg, atp_win, atp_div and atp_mul.
//
// One transaction is handled at a time. A clear is done at once from the idle state; a record
// passes through the read, evict and write steps of the window memory. A predict in fixed mode
// goes straight to the output step and may wait there for the output. In adaptive and
// complexity modes it runs the bit-serial divider that forms the average (one quotient bit
// per cycle), followed by the bit-serial multiplier; hybrid mode adds a second pass of the
// divider for the division by five. A new transaction is accepted while a finished result
// still waits on the output register.
module adaptive_timeout_predictor #(
    parameter int WINDOW_DEPTH = atp_pkg::WINDOW_DEPTH_DEF
) (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    input  logic                             i_in_valid,
    output logic                             o_in_stall,
    input  atp_pkg::t_in_item                i_in_data,
    output logic                             o_out_valid,
    input  logic                             i_out_stall,
    output atp_pkg::t_out_item               o_out_data,
    input  logic                             i_cfg_wen,
    input  logic [atp_pkg::CFG_IDX_W-1:0]    i_cfg_idx,
    input  logic [atp_pkg::DATA_W-1:0]       i_cfg_wdata
);

    localparam int CNT_W = $clog2(WINDOW_DEPTH + 1);
    localparam int SUM_W = atp_pkg::DATA_W + CNT_W;
    localparam int DVD_W = (SUM_W > atp_pkg::MIX_W) ? SUM_W : atp_pkg::MIX_W;
    localparam int DSR_W = (CNT_W > 3) ? CNT_W : 3;
    localparam int DW    = atp_pkg::DATA_W;
    localparam int PW    = atp_pkg::MUL_P_W;

    localparam logic [2:0] S_IDLE = 3'd0;
    localparam logic [2:0] S_DIV  = 3'd1;
    localparam logic [2:0] S_AMUL = 3'd2;
    localparam logic [2:0] S_MIX  = 3'd3;
    localparam logic [2:0] S_DIV5 = 3'd4;
    localparam logic [2:0] S_FIN  = 3'd5;
    localparam logic [2:0] S_WIN  = 3'd6;

    logic [2:0]                  r_state, n_state;
    logic [1:0]                  r_mode;
    logic [DW-1:0]               r_base, r_min, r_max;
    logic [atp_pkg::CPLX_W-1:0]  r_aggr;
    logic                        r_learn;
    logic [DW-1:0]               r_a_val, n_a_val;
    logic [DW-1:0]               r_c_val, n_c_val;
    logic [DW-1:0]               r_est, n_est;
    logic                        r_out_valid, n_out_valid;
    atp_pkg::t_out_item          r_out, n_out;

    logic                        accept;
    logic                        is_pred;
    atp_pkg::t_win_cmd           win_cmd;
    logic                        win_busy;
    logic [SUM_W-1:0]            win_sum;
    logic [CNT_W-1:0]            win_count;
    logic [atp_pkg::HIST_W-1:0]  win_hist;

    logic                        div_start;
    logic [DVD_W-1:0]            div_dividend;
    logic [DSR_W-1:0]            div_divisor;
    atp_pkg::t_unit_stat         div_stat;
    logic [DVD_W-1:0]            div_q;

    logic                        cmul_start;
    logic [atp_pkg::MUL_M_W-1:0] cmul_m;
    atp_pkg::t_unit_stat         cmul_stat;
    logic [PW-1:0]               cmul_p;

    logic                        amul_start;
    logic [atp_pkg::MUL_M_W-1:0] amul_m;
    atp_pkg::t_unit_stat         amul_stat;
    logic [PW-1:0]               amul_p;

    logic [11:0]                 aggr_sat;
    logic [12:0]                 aggr_sum;
    logic [atp_pkg::MIX_W-1:0]   mix_sum;
    logic [1:0]                  conf;

    function automatic logic [DW-1:0] f_clamp(
        input logic [atp_pkg::SCALED_W-1:0] x,
        input logic [DW-1:0]                lo,
        input logic [DW-1:0]                hi
    );
        logic [DW-1:0] res;
        if (x < atp_pkg::SCALED_W'(lo)) begin
            res = lo;
        end else if (x > atp_pkg::SCALED_W'(hi)) begin
            res = hi;
        end else begin
            res = x[DW-1:0];
        end
        return res;
    endfunction

    assign o_in_stall = (r_state != S_IDLE);
    assign accept     = i_in_valid && (r_state == S_IDLE);
    assign is_pred    = accept && (i_in_data.action == atp_pkg::ACT_PREDICT);

    assign win_cmd.rec    = accept && (i_in_data.action == atp_pkg::ACT_RECORD) && r_learn;
    assign win_cmd.clr    = accept && (i_in_data.action == atp_pkg::ACT_CLEAR);
    assign win_cmd.dur    = i_in_data.duration_ms;
    assign win_cmd.failed = i_in_data.timed_out;

    assign cmul_start = is_pred && (r_mode != atp_pkg::MODE_FIXED);
    assign cmul_m     = 16'(atp_pkg::ONE_Q10) + {5'b0, i_in_data.complexity}
                      + {2'b0, i_in_data.complexity, 3'b0};

    assign aggr_sat = (r_aggr > 11'(atp_pkg::ONE_Q10)) ? 12'(atp_pkg::ONE_Q10) : {1'b0, r_aggr};
    assign aggr_sum = 13'(atp_pkg::ONE_Q10) + {1'b0, aggr_sat};
    assign amul_m   = {3'b0, aggr_sum} + {2'b0, aggr_sum, 1'b0};
    assign amul_start = (r_state == S_DIV) && div_stat.done;

    assign mix_sum = {3'b0, r_a_val} + {2'b0, r_a_val, 1'b0} + {2'b0, r_c_val, 1'b0};

    assign div_start = cmul_start
                    || ((r_state == S_MIX) && (r_mode == atp_pkg::MODE_HYBRID));
    assign div_dividend = (r_state == S_MIX) ? DVD_W'(mix_sum) : DVD_W'(win_sum);
    assign div_divisor  = (r_state == S_MIX) ? DSR_W'(atp_pkg::MIX_DIVISOR)
                                             : DSR_W'(win_count);

    always_comb begin
        if (win_hist > atp_pkg::CONF_HI_TH) begin
            conf = atp_pkg::CONF_HIGH;
        end else if (win_hist > atp_pkg::CONF_MED_TH) begin
            conf = atp_pkg::CONF_MED;
        end else begin
            conf = atp_pkg::CONF_LOW;
        end
    end

    always_comb begin
        n_state     = r_state;
        n_a_val     = r_a_val;
        n_c_val     = r_c_val;
        n_est       = r_est;
        n_out_valid = r_out_valid && i_out_stall;
        n_out       = r_out;
        case (r_state)
            S_IDLE: begin
                if (win_cmd.rec) begin
                    n_state = S_WIN;
                end else if (is_pred) begin
                    if (r_mode == atp_pkg::MODE_FIXED) begin
                        n_est   = r_base;
                        n_state = S_FIN;
                    end else begin
                        n_state = S_DIV;
                    end
                end
            end
            S_WIN: begin
                if (!win_busy) begin
                    n_state = S_IDLE;
                end
            end
            S_DIV: begin
                if (div_stat.done) begin
                    n_state = S_AMUL;
                end
            end
            S_AMUL: begin
                if (amul_stat.done) begin
                    n_a_val = (win_count == '0) ? r_base
                            : f_clamp(amul_p[PW-1:atp_pkg::Q_SHIFT], r_min, r_max);
                    n_c_val = f_clamp(cmul_p[PW-1:atp_pkg::Q_SHIFT], r_min, r_max);
                    n_state = S_MIX;
                end
            end
            S_MIX: begin
                case (r_mode)
                    atp_pkg::MODE_ADAPTIVE: begin
                        n_est   = r_a_val;
                        n_state = S_FIN;
                    end
                    atp_pkg::MODE_COMPLEX: begin
                        n_est   = r_c_val;
                        n_state = S_FIN;
                    end
                    default: begin
                        n_state = S_DIV5;
                    end
                endcase
            end
            S_DIV5: begin
                if (div_stat.done) begin
                    n_est   = div_q[DW-1:0];
                    n_state = S_FIN;
                end
            end
            S_FIN: begin
                if (!r_out_valid || !i_out_stall) begin
                    n_out.predicted_ms = f_clamp(atp_pkg::SCALED_W'(r_est), r_min, r_max);
                    n_out.confidence   = conf;
                    n_out_valid        = 1'b1;
                    n_state            = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_out_valid <= 1'b0;
            r_mode      <= atp_pkg::RST_MODE;
            r_base      <= atp_pkg::RST_BASE;
            r_min       <= atp_pkg::RST_MIN;
            r_max       <= atp_pkg::RST_MAX;
            r_aggr      <= atp_pkg::RST_AGGR;
            r_learn     <= 1'b1;
        end else begin
            r_state     <= n_state;
            r_out_valid <= n_out_valid;
            if (i_cfg_wen) begin
                case (i_cfg_idx)
                    atp_pkg::CFG_MODE:  r_mode  <= i_cfg_wdata[1:0];
                    atp_pkg::CFG_BASE:  r_base  <= i_cfg_wdata;
                    atp_pkg::CFG_MIN:   r_min   <= i_cfg_wdata;
                    atp_pkg::CFG_MAX:   r_max   <= i_cfg_wdata;
                    atp_pkg::CFG_AGGR:  r_aggr  <= i_cfg_wdata[atp_pkg::CPLX_W-1:0];
                    atp_pkg::CFG_LEARN: r_learn <= i_cfg_wdata[0];
                    default: begin
                    end
                endcase
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_a_val <= n_a_val;
        r_c_val <= n_c_val;
        r_est   <= n_est;
        r_out   <= n_out;
    end

    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out;

    atp_win #(
        .DEPTH(WINDOW_DEPTH)
    ) u_win (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_cmd     (win_cmd),
        .o_busy    (win_busy),
        .o_sum     (win_sum),
        .o_count   (win_count),
        .o_history (win_hist)
    );

    atp_div #(
        .DVD_W(DVD_W),
        .DSR_W(DSR_W)
    ) u_div (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (div_start),
        .i_dividend (div_dividend),
        .i_divisor  (div_divisor),
        .o_stat     (div_stat),
        .o_quotient (div_q)
    );

    atp_mul #(
        .X_W(atp_pkg::MUL_X_W),
        .M_W(atp_pkg::MUL_M_W)
    ) u_cmul (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_start   (cmul_start),
        .i_x       (r_base),
        .i_m       (cmul_m),
        .o_stat    (cmul_stat),
        .o_product (cmul_p)
    );

    atp_mul #(
        .X_W(atp_pkg::MUL_X_W),
        .M_W(atp_pkg::MUL_M_W)
    ) u_amul (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_start   (amul_start),
        .i_x       (div_q[DW-1:0]),
        .i_m       (amul_m),
        .o_stat    (amul_stat),
        .o_product (amul_p)
    );

    a_div_idle_on_start: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        div_start |-> !div_stat.busy)
        else $error("divider started while still busy");

    a_cmul_done_at_mix: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_MIX) |-> !cmul_stat.busy)
        else $error("complexity product not ready when estimates are combined");

    a_amul_done_in_order: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        amul_stat.done |-> (r_state == S_AMUL))
        else $error("adaptive product finished outside its wait state");

endmodule

FILE: bench/tb_adaptive_timeout_predictor.sv
`timescale 1ns / 1ps
// Self-checking testbench for adaptive_timeout_predictor: drives record, predict, clear
// and undefined transactions under random idling, checks every estimate against its own
// window model. Depends on atp_pkg and the adaptive_timeout_predictor RTL.
module tb_adaptive_timeout_predictor;

    localparam int WIN_DEPTH     = atp_pkg::WINDOW_DEPTH_DEF;
    localparam int DW            = atp_pkg::DATA_W;
    localparam int CW            = atp_pkg::CPLX_W;
    localparam int IW            = atp_pkg::CFG_IDX_W;
    localparam int SETTLE_CYCLES = 200;
    localparam int MAX_REPORTS   = 10;

    localparam logic [1:0]    ACT_UNDEFINED = 2'd3;
    localparam logic [IW-1:0] CFG_SPARE_LO  = 3'd6;
    localparam logic [IW-1:0] CFG_SPARE_HI  = 3'd7;

    logic                 i_clk       = 1'b0;
    logic                 i_rst_n     = 1'b0;
    logic                 i_in_valid  = 1'b0;
    logic                 o_in_stall;
    atp_pkg::t_in_item    i_in_data   = '0;
    logic                 o_out_valid;
    logic                 i_out_stall = 1'b0;
    atp_pkg::t_out_item   o_out_data;
    logic                 i_cfg_wen   = 1'b0;
    logic [IW-1:0]        i_cfg_idx   = '0;
    logic [DW-1:0]        i_cfg_wdata = '0;

    adaptive_timeout_predictor dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_stall  (o_in_stall),
        .i_in_data   (i_in_data),
        .o_out_valid (o_out_valid),
        .i_out_stall (i_out_stall),
        .o_out_data  (o_out_data),
        .i_cfg_wen   (i_cfg_wen),
        .i_cfg_idx   (i_cfg_idx),
        .i_cfg_wdata (i_cfg_wdata)
    );

    always #2ns i_clk = ~i_clk;

    // Mirror of the registers and the execution window.
    logic [1:0]    cfg_mode;
    logic [DW-1:0] cfg_base, cfg_min, cfg_max;
    logic [CW-1:0] cfg_aggr;
    logic          cfg_learn;

    logic [DW-1:0] win_dur [WIN_DEPTH];
    bit            win_fail [WIN_DEPTH];
    int unsigned   win_fill, win_slot, ok_count, hist_count;
    logic [63:0]   ok_sum;

    atp_pkg::t_out_item pending_estimates [$];
    int                 fail_count    = 0;
    int                 send_idle_pct = 0;
    int                 stall_pct     = 0;
    int                 hold_left     = 0;

    function automatic void report_fail(input string what, input logic [63:0] want,
                                        input logic [63:0] got);
        fail_count++;
        if (fail_count <= MAX_REPORTS)
            $display("%0t ns: %s: expected %0d, actual %0d", $realtime, what, want, got);
    endfunction

    function automatic void clear_window();
        foreach (win_fail[k]) win_fail[k] = 1'b0;
        win_fill   = 0;
        win_slot   = 0;
        ok_sum     = '0;
        ok_count   = 0;
        hist_count = 0;
    endfunction

    function automatic logic [63:0] clamp_ms(input logic [63:0] x);
        if (x < 64'(cfg_min)) return 64'(cfg_min);
        if (x > 64'(cfg_max)) return 64'(cfg_max);
        return x;
    endfunction

    function automatic logic [63:0] adaptive_ms();
        logic [63:0] aggr, mean;
        if (ok_count == 0) return 64'(cfg_base);
        aggr = (cfg_aggr > atp_pkg::ONE_Q10) ? 64'(atp_pkg::ONE_Q10) : 64'(cfg_aggr);
        mean = ok_sum / 64'(ok_count);
        return clamp_ms((mean * 64'd3 * (64'(atp_pkg::ONE_Q10) + aggr)) / 64'd2048);
    endfunction

    function automatic logic [63:0] complexity_ms(input logic [CW-1:0] c);
        return clamp_ms((64'(cfg_base) * (64'(atp_pkg::ONE_Q10) + 64'd9 * 64'(c)))
                        / 64'd2048);
    endfunction

    function automatic logic [63:0] estimate_ms(input logic [CW-1:0] c);
        logic [63:0] est;
        case (cfg_mode)
            atp_pkg::MODE_FIXED:    est = 64'(cfg_base);
            atp_pkg::MODE_ADAPTIVE: est = adaptive_ms();
            atp_pkg::MODE_COMPLEX:  est = complexity_ms(c);
            default: est = (64'd3 * adaptive_ms() + 64'd2 * complexity_ms(c)) / 64'd5;
        endcase
        return clamp_ms(est);
    endfunction

    task automatic absorb_transaction(input atp_pkg::t_in_item it);
        atp_pkg::t_out_item want;
        logic [63:0]        est;
        int unsigned        s;
        case (it.action)
            atp_pkg::ACT_RECORD: begin
                if (cfg_learn) begin
                    s = win_slot;
                    if (win_fill >= WIN_DEPTH) begin
                        if (!win_fail[s]) begin
                            ok_sum = ok_sum - 64'(win_dur[s]);
                            if (ok_count > 0) ok_count--;
                        end
                    end else begin
                        win_fill++;
                    end
                    win_dur[s]  = it.duration_ms;
                    win_fail[s] = it.timed_out;
                    if (!it.timed_out) begin
                        ok_sum = ok_sum + 64'(it.duration_ms);
                        ok_count++;
                    end
                    win_slot = (s + 1 >= WIN_DEPTH) ? 0 : s + 1;
                    if (hist_count < atp_pkg::HISTORY_SAT) hist_count++;
                end
            end
            atp_pkg::ACT_CLEAR: clear_window();
            atp_pkg::ACT_PREDICT: begin
                est = estimate_ms(it.complexity);
                want.predicted_ms = est[DW-1:0];
                if (hist_count > atp_pkg::CONF_HI_TH) want.confidence = atp_pkg::CONF_HIGH;
                else if (hist_count > atp_pkg::CONF_MED_TH) want.confidence = atp_pkg::CONF_MED;
                else want.confidence = atp_pkg::CONF_LOW;
                pending_estimates = {pending_estimates, want};
            end
            default: ;
        endcase
    endtask

    always @(posedge i_clk) begin : check_results
        atp_pkg::t_out_item want;
        if (i_rst_n && o_out_valid && !i_out_stall) begin
            if (pending_estimates.size() == 0) begin
                report_fail("result with no transaction pending", '0,
                            64'(o_out_data.predicted_ms));
            end else begin
                want = pending_estimates.pop_front();
                if (o_out_data.predicted_ms !== want.predicted_ms)
                    report_fail("predicted_ms", 64'(want.predicted_ms),
                                64'(o_out_data.predicted_ms));
                if (o_out_data.confidence !== want.confidence)
                    report_fail("confidence", 64'(want.confidence),
                                64'(o_out_data.confidence));
            end
        end
    end

    // A long hold-off takes precedence over the random stalls.
    always @(posedge i_clk) begin
        if (hold_left > 0) begin
            hold_left = hold_left - 1;
            i_out_stall <= 1'b1;
        end else begin
            i_out_stall <= ($urandom_range(99) < stall_pct);
        end
    end

    initial begin
        #4_000_000;
        $display("adaptive_timeout_predictor regression: fail");
        $finish;
    end

    task automatic send_item(input atp_pkg::t_in_item it);
        while ($urandom_range(99) < send_idle_pct) begin
            i_in_valid <= 1'b0;
            @(posedge i_clk);
        end
        i_in_valid <= 1'b1;
        i_in_data  <= it;
        @(posedge i_clk);
        while (o_in_stall) @(posedge i_clk);
        absorb_transaction(it);
    endtask

    task automatic pause_sender();
        i_in_valid <= 1'b0;
        @(posedge i_clk);
        while (pending_estimates.size() != 0) @(posedge i_clk);
    endtask

    task automatic settle_block();
        pause_sender();
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    task automatic write_reg(input logic [IW-1:0] idx, input logic [DW-1:0] val);
        i_cfg_wen   <= 1'b1;
        i_cfg_idx   <= idx;
        i_cfg_wdata <= val;
        @(posedge i_clk);
        i_cfg_wen <= 1'b0;
        case (idx)
            atp_pkg::CFG_MODE:  cfg_mode  = val[1:0];
            atp_pkg::CFG_BASE:  cfg_base  = val;
            atp_pkg::CFG_MIN:   cfg_min   = val;
            atp_pkg::CFG_MAX:   cfg_max   = val;
            atp_pkg::CFG_AGGR:  cfg_aggr  = val[CW-1:0];
            atp_pkg::CFG_LEARN: cfg_learn = val[0];
            default: ;
        endcase
        @(posedge i_clk);
    endtask

    task automatic set_idling(input int send_pct, input int recv_pct);
        send_idle_pct = send_pct;
        stall_pct     = recv_pct;
    endtask

    function automatic atp_pkg::t_in_item make_item(input logic [1:0] act,
                                                    input logic [DW-1:0] dur,
                                                    input logic tout,
                                                    input logic [CW-1:0] c);
        atp_pkg::t_in_item it;
        it.action      = act;
        it.duration_ms = dur;
        it.timed_out   = tout;
        it.complexity  = c;
        return it;
    endfunction

    function automatic logic [DW-1:0] random_duration();
        case ($urandom_range(9))
            0:       return $urandom;
            1, 2, 3: return $urandom_range(5_000_000, 1000);
            default: return $urandom_range(100_000);
        endcase
    endfunction

    function automatic logic [CW-1:0] random_complexity();
        if ($urandom_range(99) < 15) return CW'($urandom_range(2047));
        return CW'($urandom_range(atp_pkg::ONE_Q10));
    endfunction

    function automatic atp_pkg::t_in_item random_record();
        return make_item(atp_pkg::ACT_RECORD, random_duration(), $urandom_range(99) < 25,
                         CW'($urandom_range(2047)));
    endfunction

    function automatic atp_pkg::t_in_item random_predict();
        return make_item(atp_pkg::ACT_PREDICT, $urandom, 1'($urandom_range(1)),
                         random_complexity());
    endfunction

    function automatic atp_pkg::t_in_item random_noise();
        return make_item(($urandom_range(2) == 0) ? atp_pkg::ACT_CLEAR : ACT_UNDEFINED,
                         $urandom, 1'($urandom_range(1)), CW'($urandom_range(2047)));
    endfunction

    task automatic randomise_config();
        write_reg(atp_pkg::CFG_MODE, $urandom_range(3));
        write_reg(atp_pkg::CFG_BASE,
                  ($urandom_range(9) == 0) ? $urandom : $urandom_range(200_000, 100));
        if ($urandom_range(9) == 0) begin
            write_reg(atp_pkg::CFG_MIN, $urandom);
            write_reg(atp_pkg::CFG_MAX, $urandom);
        end else begin
            write_reg(atp_pkg::CFG_MIN, $urandom_range(20_000));
            write_reg(atp_pkg::CFG_MAX, $urandom_range(10_000_000, 30_000));
        end
        write_reg(atp_pkg::CFG_AGGR, ($urandom_range(4) == 0)
                                     ? $urandom_range(2047)
                                     : $urandom_range(atp_pkg::ONE_Q10));
        write_reg(atp_pkg::CFG_LEARN, DW'($urandom_range(9) != 0));
    endtask

    task automatic run_sequences(input int n_items);
        int sent;
        sent = 0;
        while (sent < n_items) begin
            repeat ($urandom_range(25, 1)) begin
                send_item(random_record());
                sent++;
            end
            repeat ($urandom_range(3, 1)) begin
                send_item(random_predict());
                sent++;
            end
            if ($urandom_range(99) < 10) begin
                send_item(random_noise());
                sent++;
            end
        end
    endtask

    task automatic test_reset_state();
        send_item(make_item(atp_pkg::ACT_PREDICT, '0, 1'b0, '0));
        send_item(make_item(atp_pkg::ACT_PREDICT, '1, 1'b1, 11'd1024));
    endtask

    task automatic test_strategies();
        logic [DW-1:0] aggr_vals [3];
        aggr_vals = '{32'd0, 32'd1024, 32'd2047};
        send_item(make_item(atp_pkg::ACT_RECORD, 32'd0, 1'b0, '0));
        send_item(make_item(atp_pkg::ACT_RECORD, 32'hFFFF_FFFF, 1'b0, '1));
        send_item(make_item(atp_pkg::ACT_RECORD, 32'd12345, 1'b1, '0));
        send_item(make_item(ACT_UNDEFINED, '1, 1'b1, '1));
        send_item(make_item(atp_pkg::ACT_PREDICT, '0, 1'b0, 11'd2047));
        settle_block();
        write_reg(atp_pkg::CFG_MODE, DW'(atp_pkg::MODE_FIXED));
        send_item(make_item(atp_pkg::ACT_PREDICT, '0, 1'b0, 11'd5));
        settle_block();
        write_reg(atp_pkg::CFG_MODE, DW'(atp_pkg::MODE_ADAPTIVE));
        send_item(make_item(atp_pkg::ACT_PREDICT, '0, 1'b0, '0));
        foreach (aggr_vals[k]) begin
            settle_block();
            write_reg(atp_pkg::CFG_AGGR, aggr_vals[k]);
            send_item(make_item(atp_pkg::ACT_PREDICT, '0, 1'b0, '0));
        end
        settle_block();
        write_reg(atp_pkg::CFG_MODE, DW'(atp_pkg::MODE_COMPLEX));
        send_item(make_item(atp_pkg::ACT_PREDICT, '0, 1'b0, 11'd0));
        send_item(make_item(atp_pkg::ACT_PREDICT, '0, 1'b0, 11'd1024));
        send_item(make_item(atp_pkg::ACT_PREDICT, '0, 1'b0, 11'd2047));
        send_item(make_item(atp_pkg::ACT_CLEAR, '0, 1'b0, '0));
        settle_block();
        write_reg(atp_pkg::CFG_MODE, DW'(atp_pkg::MODE_ADAPTIVE));
        send_item(make_item(atp_pkg::ACT_PREDICT, '0, 1'b0, '0));
        settle_block();
        write_reg(atp_pkg::CFG_MODE, DW'(atp_pkg::MODE_HYBRID));
        write_reg(atp_pkg::CFG_AGGR, DW'(atp_pkg::RST_AGGR));
        send_item(make_item(atp_pkg::ACT_PREDICT, '0, 1'b0, 11'd700));
    endtask

    task automatic test_register_extremes();
        settle_block();
        write_reg(CFG_SPARE_LO, '1);
        write_reg(CFG_SPARE_HI, '1);
        write_reg(atp_pkg::CFG_MIN, '0);
        write_reg(atp_pkg::CFG_MAX, '1);
        write_reg(atp_pkg::CFG_BASE, '1);
        write_reg(atp_pkg::CFG_MODE, DW'(atp_pkg::MODE_COMPLEX));
        send_item(make_item(atp_pkg::ACT_PREDICT, '0, 1'b0, 11'd2047));
        send_item(make_item(atp_pkg::ACT_PREDICT, '0, 1'b0, 11'd0));
        settle_block();
        write_reg(atp_pkg::CFG_BASE, '0);
        send_item(make_item(atp_pkg::ACT_PREDICT, '0, 1'b0, 11'd1024));
        settle_block();
        write_reg(atp_pkg::CFG_BASE, atp_pkg::RST_BASE);
        write_reg(atp_pkg::CFG_MIN, 32'd40000);
        write_reg(atp_pkg::CFG_MAX, 32'd1000);
        write_reg(atp_pkg::CFG_MODE, DW'(atp_pkg::MODE_HYBRID));
        send_item(make_item(atp_pkg::ACT_RECORD, 32'd2_000_000, 1'b0, '0));
        send_item(make_item(atp_pkg::ACT_RECORD, 32'd10, 1'b0, '0));
        send_item(make_item(atp_pkg::ACT_PREDICT, '0, 1'b0, 11'd300));
        settle_block();
        write_reg(atp_pkg::CFG_MIN, atp_pkg::RST_MIN);
        write_reg(atp_pkg::CFG_MAX, atp_pkg::RST_MAX);
    endtask

    task automatic test_window_wrap();
        settle_block();
        set_idling(28, 28);
        send_item(make_item(atp_pkg::ACT_CLEAR, '0, 1'b0, '0));
        for (int n = 1; n <= 130; n++) begin
            send_item(random_record());
            if (n % 10 == 0) send_item(random_predict());
        end
        send_item(random_predict());
    endtask

    task automatic test_learning_off();
        settle_block();
        set_idling(0, 0);
        write_reg(atp_pkg::CFG_LEARN, DW'(1'b0));
        repeat (4) send_item(random_record());
        send_item(random_predict());
        send_item(make_item(atp_pkg::ACT_CLEAR, '0, 1'b0, '0));
        send_item(random_predict());
        send_item(random_record());
        send_item(random_predict());
        settle_block();
        write_reg(atp_pkg::CFG_LEARN, DW'(1'b1));
    endtask

    task automatic test_random_traffic();
        for (int ph = 0; ph < 4; ph++) begin
            case (ph)
                0:       set_idling(0, 0);
                1:       set_idling(84, 0);
                2:       set_idling(0, 84);
                default: set_idling(28, 28);
            endcase
            repeat (2) begin
                settle_block();
                randomise_config();
                run_sequences(40);
            end
        end
    endtask

    task automatic test_output_holdoff();
        settle_block();
        set_idling(0, 0);
        write_reg(atp_pkg::CFG_MODE, DW'(atp_pkg::MODE_HYBRID));
        write_reg(atp_pkg::CFG_LEARN, DW'(1'b1));
        hold_left = 400;
        repeat (10) begin
            send_item(random_record());
            send_item(random_predict());
        end
    endtask

    task automatic test_sender_pause();
        set_idling(0, 28);
        repeat (4) begin
            send_item(random_record());
            send_item(random_predict());
        end
        pause_sender();
        repeat (4) begin
            send_item(random_predict());
            send_item(random_record());
        end
    endtask

    initial begin
        cfg_mode  = atp_pkg::RST_MODE;
        cfg_base  = atp_pkg::RST_BASE;
        cfg_min   = atp_pkg::RST_MIN;
        cfg_max   = atp_pkg::RST_MAX;
        cfg_aggr  = atp_pkg::RST_AGGR;
        cfg_learn = 1'b1;
        clear_window();
        repeat (9) @(posedge i_clk);
        i_rst_n <= 1'b1;
        test_reset_state();
        test_strategies();
        test_register_extremes();
        test_window_wrap();
        test_learning_off();
        test_random_traffic();
        test_output_holdoff();
        test_sender_pause();
        settle_block();
        if (pending_estimates.size() != 0)
            report_fail("transactions left without a result", '0,
                        64'(pending_estimates.size()));
        if (fail_count == 0) begin
            $display("adaptive_timeout_predictor regression: pass");
        end else begin
            $display("adaptive_timeout_predictor regression: fail");
        end
        $finish;
    end

endmodule
